// ----- rtl/m2ump_pkg.sv -----
// Package: message codes, packet field constants and value upscaling functions.
package m2ump_pkg;

    // UMP message types
    localparam logic [3:0] MT_SYS = 4'h1;
    localparam logic [3:0] MT_CV2 = 4'h4;

    // UMP group used for every packet
    localparam logic [3:0] UMP_GROUP = 4'h0;

    // MIDI 1.0 channel voice opcodes (upper nibble of the status byte)
    localparam logic [3:0] OP_NOTE_OFF   = 4'h8;
    localparam logic [3:0] OP_NOTE_ON    = 4'h9;
    localparam logic [3:0] OP_POLY_PRESS = 4'hA;
    localparam logic [3:0] OP_CTRL       = 4'hB;
    localparam logic [3:0] OP_PROGRAM    = 4'hC;
    localparam logic [3:0] OP_CHAN_PRESS = 4'hD;
    localparam logic [3:0] OP_PITCH_BEND = 4'hE;
    localparam logic [3:0] OP_SYSTEM     = 4'hF;

    // System common and real-time status bytes
    localparam logic [7:0] ST_MTC_QTR    = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
    localparam logic [7:0] ST_CLOCK      = 8'hF8;
    localparam logic [7:0] ST_START      = 8'hFA;
    localparam logic [7:0] ST_CONTINUE   = 8'hFB;
    localparam logic [7:0] ST_STOP       = 8'hFC;
    localparam logic [7:0] ST_ACT_SENSE  = 8'hFE;
    localparam logic [7:0] ST_SYS_RESET  = 8'hFF;

    // Controllers that the MIDI 2.0 protocol carries by other means
    localparam logic [6:0] CC_BANK_MSB   = 7'd0;
    localparam logic [6:0] CC_DATA_MSB   = 7'd6;
    localparam logic [6:0] CC_BANK_LSB   = 7'd32;
    localparam logic [6:0] CC_DATA_LSB   = 7'd38;
    localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
    localparam logic [6:0] CC_RPN_MSB    = 7'd101;

    // Velocity sent for a note-on with zero velocity turned into a note-off
    localparam logic [15:0] VEL_CENTRE   = 16'h8000;

    // Result codes
    localparam logic RC_OK          = 1'b0;
    localparam logic RC_UNSUPPORTED = 1'b1;

    // 7 to 16 bit upscale: zero, centre and full scale map exactly,
    // other values repeat their low six bits below the top bit.
    function automatic logic [15:0] up7to16(input logic [6:0] v);
        logic [14:0] rep;
        rep = {v[5:0], 9'd0} | {7'd0, v[5:0], 2'd0} | {14'd0, v[5]};
        if (v == 7'h7F) begin
            return 16'hFFFF;
        end
        return {v[6], rep};
    endfunction

    // 7 to 32 bit upscale
    function automatic logic [31:0] up7to32(input logic [6:0] v);
        logic [30:0] rep;
        rep = {v[5:0], 25'd0} | {7'd0, v[5:0], 18'd0} | {14'd0, v[5:0], 11'd0}
            | {21'd0, v[5:0], 4'd0} | {28'd0, v[5:3]};
        if (v == 7'h7F) begin
            return 32'hFFFF_FFFF;
        end
        return {v[6], rep};
    endfunction

    // 14 to 32 bit upscale
    function automatic logic [31:0] up14to32(input logic [13:0] v);
        logic [30:0] rep;
        rep = {v[12:0], 18'd0} | {14'd0, v[12:0], 4'd0} | {28'd0, v[12:10]};
        if (v == 14'h3FFF) begin
            return 32'hFFFF_FFFF;
        end
        return {v[13], rep};
    endfunction

endpackage

// ----- rtl/midi1_to_ump_midi2_translator_core.sv -----
// Top level: MIDI 1.0 message to two-word MIDI 2.0 UMP translator.
// Path: an accepted message moves through the input register, then the result
// register, before it is presented on the output.
// Throughput: one message per cycle; the input stalls only when both
// registers are full and the output side is stalling.
// Reset (synchronous, active low) clears both valid flags; payload is not reset.
module midi1_to_ump_midi2_translator_core
    import m2ump_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_status_in,
    input  logic [7:0]  i_data_first,
    input  logic [7:0]  i_data_second,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_word_first,
    output logic [31:0] o_word_second,
    output logic        o_result_code
);

    // Input register stage
    logic       r_in_valid;
    logic [7:0] r_status;
    logic [6:0] r_data_first;
    logic [6:0] r_data_second;

    // Result register stage
    logic        r_out_valid;
    logic [31:0] r_word_first;
    logic [31:0] r_word_second;
    logic        r_result_code;

    logic        n_word_first_ok;
    logic [31:0] n_word_first;
    logic [31:0] n_word_second;
    logic        n_result_code;

    logic adv_out;
    logic adv_in;

    // The result register takes a new transfer whenever it is empty or being
    // drained; the input register advances whenever its contents can move on.
    assign adv_out = !r_out_valid || !i_stall;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_stall = !adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_valid;
        end
        // Data bytes carry seven bits only: drop the top bit on capture.
        if (adv_in && i_valid) begin
            r_status      <= i_status_in;
            r_data_first  <= i_data_first[6:0];
            r_data_second <= i_data_second[6:0];
        end
    end

    // Translation: one decode of the status byte, then field packing.
    // Word 0 layout: type[31:28] group[27:24] status[23:16] index[15:8] low[7:0].
    always_comb begin
        n_word_first_ok = 1'b1;
        n_word_first    = 32'd0;
        n_word_second   = 32'd0;
        unique case (r_status[7:4])
            OP_SYSTEM: begin
                unique case (r_status) inside
                    ST_MTC_QTR, ST_SONG_SEL: begin
                        n_word_first = {MT_SYS, UMP_GROUP, r_status, 1'b0, r_data_first,
                                        8'd0};
                    end
                    ST_SONG_POS: begin
                        n_word_first = {MT_SYS, UMP_GROUP, r_status, 1'b0, r_data_first,
                                        1'b0, r_data_second};
                    end
                    ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP,
                    ST_ACT_SENSE, ST_SYS_RESET: begin
                        n_word_first = {MT_SYS, UMP_GROUP, r_status, 16'd0};
                    end
                    // System exclusive and undefined system codes
                    default: begin
                        n_word_first_ok = 1'b0;
                    end
                endcase
            end
            OP_NOTE_OFF: begin
                n_word_first  = {MT_CV2, UMP_GROUP, r_status, 1'b0, r_data_first, 8'd0};
                n_word_second = {up7to16(r_data_second), 16'd0};
            end
            OP_NOTE_ON: begin
                // Zero velocity means note-off at centre velocity.
                if (r_data_second == 7'd0) begin
                    n_word_first  = {MT_CV2, UMP_GROUP, OP_NOTE_OFF, r_status[3:0],
                                     1'b0, r_data_first, 8'd0};
                    n_word_second = {VEL_CENTRE, 16'd0};
                end else begin
                    n_word_first  = {MT_CV2, UMP_GROUP, r_status, 1'b0, r_data_first,
                                     8'd0};
                    n_word_second = {up7to16(r_data_second), 16'd0};
                end
            end
            OP_POLY_PRESS: begin
                n_word_first  = {MT_CV2, UMP_GROUP, r_status, 1'b0, r_data_first, 8'd0};
                n_word_second = up7to32(r_data_second);
            end
            OP_CTRL: begin
                // Bank select, data entry and (N)RPN controllers are not carried.
                if (r_data_first == CC_BANK_MSB || r_data_first == CC_DATA_MSB ||
                    r_data_first == CC_BANK_LSB || r_data_first == CC_DATA_LSB ||
                    (r_data_first >= CC_NRPN_LSB && r_data_first <= CC_RPN_MSB)) begin
                    n_word_first_ok = 1'b0;
                end else begin
                    n_word_first  = {MT_CV2, UMP_GROUP, r_status, 1'b0, r_data_first,
                                     8'd0};
                    n_word_second = up7to32(r_data_second);
                end
            end
            OP_PROGRAM: begin
                // Bank-valid flag stays clear; program in the top byte.
                n_word_first  = {MT_CV2, UMP_GROUP, r_status, 16'd0};
                n_word_second = {1'b0, r_data_first, 24'd0};
            end
            OP_CHAN_PRESS: begin
                n_word_first  = {MT_CV2, UMP_GROUP, r_status, 16'd0};
                n_word_second = up7to32(r_data_first);
            end
            OP_PITCH_BEND: begin
                n_word_first  = {MT_CV2, UMP_GROUP, r_status, 16'd0};
                n_word_second = up14to32({r_data_second, r_data_first});
            end
            // Data bytes in the status position
            default: begin
                n_word_first_ok = 1'b0;
            end
        endcase

        // Unsupported: both words read as zero.
        if (!n_word_first_ok) begin
            n_word_first  = 32'd0;
            n_word_second = 32'd0;
        end
        n_result_code = n_word_first_ok ? RC_OK : RC_UNSUPPORTED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
        // Hold the result while the output side stalls.
        if (adv_out && r_in_valid) begin
            r_word_first  <= n_word_first;
            r_word_second <= n_word_second;
            r_result_code <= n_result_code;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_word_first  = r_word_first;
    assign o_word_second = r_word_second;
    assign o_result_code = r_result_code;

endmodule

// ----- verif/midi1_to_ump_midi2_translator_core_tb.sv -----
// Testbench for the MIDI 1.0 to MIDI 2.0 UMP translator core: directed table, then random traffic.
`timescale 1ns / 100ps

module midi1_to_ump_midi2_translator_core_tb;
    import m2ump_pkg::*;

    // One translated packet as it leaves the core
    typedef struct packed {
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic        result_code;
    } t_packet;

    // One row of the directed table; known marks rows whose packet is typed in
    typedef struct packed {
        logic [7:0]  st;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic        known;
        logic [31:0] w0;
        logic [31:0] w1;
        logic        rc;
    } t_dir_row;

    localparam int N_DIR    = 28;
    localparam int N_RANDOM = 1100;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_status_in   = 8'h00;
    logic [7:0]  i_data_first  = 8'h00;
    logic [7:0]  i_data_second = 8'h00;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_word_first;
    logic [31:0] o_word_second;
    logic        o_result_code;

    // Expectation travelling with the payload currently presented
    logic        cur_known = 1'b0;
    t_packet     cur_want  = '0;

    // Transfer flags, taken mid-cycle for the coming rising edge
    logic        in_take  = 1'b0;
    logic        out_take = 1'b0;

    t_packet     due_packets [$];
    t_packet     want_pkt;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          n_errors       = 0;
    int          n_sent         = 0;
    int          n_checked      = 0;
    int          n_voice        = 0;
    int          n_system       = 0;
    int          n_unsupported  = 0;

    // Directed table: extremes, every opcode, reserved controllers, zero velocity,
    // masked data bits, unsupported system bytes and status bytes below 0x80.
    t_dir_row dir_rows [N_DIR] = '{
        '{8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'h7F, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'h80, 8'h00, 8'h00, 1'b1, 32'h4080_0000, 32'h0000_0000, RC_OK},
        '{8'h8F, 8'hFF, 8'hFF, 1'b1, 32'h408F_7F00, 32'hFFFF_0000, RC_OK},
        '{8'h93, 8'h3C, 8'h00, 1'b1, 32'h4083_3C00, 32'h8000_0000, RC_OK},
        '{8'h90, 8'h3C, 8'h40, 1'b1, 32'h4090_3C00, 32'h8000_0000, RC_OK},
        '{8'h95, 8'h45, 8'h23, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hA1, 8'h10, 8'h7F, 1'b1, 32'h40A1_1000, 32'hFFFF_FFFF, RC_OK},
        '{8'hA2, 8'h91, 8'h15, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hB0, 8'h00, 8'h40, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hB3, 8'h26, 8'h7F, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hB0, 8'h62, 8'h10, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hBF, 8'hE5, 8'h10, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hB4, 8'h61, 8'h2A, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hB4, 8'h66, 8'h55, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hC7, 8'hFF, 8'hFF, 1'b1, 32'h40C7_0000, 32'h7F00_0000, RC_OK},
        '{8'hDA, 8'h40, 8'h00, 1'b1, 32'h40DA_0000, 32'h8000_0000, RC_OK},
        '{8'hD1, 8'h33, 8'h00, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hEF, 8'h00, 8'h00, 1'b1, 32'h40EF_0000, 32'h0000_0000, RC_OK},
        '{8'hE0, 8'h00, 8'h40, 1'b1, 32'h40E0_0000, 32'h8000_0000, RC_OK},
        '{8'hE5, 8'h7F, 8'h7F, 1'b1, 32'h40E5_0000, 32'hFFFF_FFFF, RC_OK},
        '{8'hE2, 8'h12, 8'h34, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hF2, 8'h7F, 8'h7F, 1'b1, 32'h10F2_7F7F, 32'h0000_0000, RC_OK},
        '{8'hF1, 8'h23, 8'h45, 1'b0, 32'h0,         32'h0,         RC_OK},
        '{8'hF0, 8'h12, 8'h34, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hFD, 8'h00, 8'h00, 1'b1, 32'h0000_0000, 32'h0000_0000, RC_UNSUPPORTED},
        '{8'hF8, 8'h55, 8'h66, 1'b1, 32'h10F8_0000, 32'h0000_0000, RC_OK},
        '{8'hFF, 8'h7F, 8'h7F, 1'b1, 32'h10FF_0000, 32'h0000_0000, RC_OK}
    };

    midi1_to_ump_midi2_translator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_status_in   (i_status_in),
        .i_data_first  (i_data_first),
        .i_data_second (i_data_second),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word_first  (o_word_first),
        .o_word_second (o_word_second),
        .o_result_code (o_result_code)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #100000;
        $display("timeout: %0d packets still due", due_packets.size());
        $display("TEST FAILED");
        $finish;
    end

    // Velocity scaling, 7 to 16 bits: exact at zero, centre and full scale,
    // bit repetition elsewhere.
    function automatic logic [15:0] vel_to_16(input logic [6:0] v);
        logic [15:0] x;
        x = {9'd0, v};
        if (v == 7'h00) return 16'h0000;
        if (v == 7'h40) return VEL_CENTRE;
        if (v == 7'h7F) return 16'hFFFF;
        if (!v[6]) return (x << 9) | (x << 2) | (x >> 5);
        x = x - 16'h0040;
        return 16'h8000 + (x << 9) + (x << 2) + (x >> 5);
    endfunction

    // Pressure and controller scaling, 7 to 32 bits
    function automatic logic [31:0] val_to_32(input logic [6:0] v);
        logic [31:0] x;
        x = {25'd0, v};
        if (v == 7'h00) return 32'h0000_0000;
        if (v == 7'h40) return 32'h8000_0000;
        if (v == 7'h7F) return 32'hFFFF_FFFF;
        if (!v[6]) return (x << 25) | (x << 18) | (x << 11) | (x << 4) | (x >> 3);
        x = x - 32'h40;
        return 32'h8000_0000 + (x << 25) + (x << 18) + (x << 11) + (x << 4) + (x >> 3);
    endfunction

    // Pitch bend scaling, 14 to 32 bits
    function automatic logic [31:0] bend_to_32(input logic [13:0] v);
        logic [31:0] x;
        x = {18'd0, v};
        if (v == 14'h0000) return 32'h0000_0000;
        if (v == 14'h2000) return 32'h8000_0000;
        if (v == 14'h3FFF) return 32'hFFFF_FFFF;
        if (!v[13]) return (x << 18) | (x << 4) | (x >> 10);
        x = x - 32'h2000;
        return 32'h8000_0000 + (x << 18) + (x << 4) + (x >> 10);
    endfunction

    // Work out the packet that one MIDI 1.0 message must turn into
    function automatic t_packet translate_msg(input logic [7:0] st, input logic [7:0] b1,
                                              input logic [7:0] b2);
        t_packet    p;
        logic [6:0] d1;
        logic [6:0] d2;
        d1 = b1[6:0];
        d2 = b2[6:0];
        p  = '0;
        p.result_code = RC_OK;
        if (st[7:4] == OP_SYSTEM) begin
            case (st)
                ST_MTC_QTR, ST_SONG_SEL: begin
                    p.word_first = {MT_SYS, UMP_GROUP, st, 1'b0, d1, 8'h00};
                end
                ST_SONG_POS: begin
                    p.word_first = {MT_SYS, UMP_GROUP, st, 1'b0, d1, 1'b0, d2};
                end
                ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP, ST_ACT_SENSE,
                ST_SYS_RESET: begin
                    p.word_first = {MT_SYS, UMP_GROUP, st, 16'h0000};
                end
                default: begin
                    p.result_code = RC_UNSUPPORTED;
                end
            endcase
        end else begin
            case (st[7:4])
                OP_NOTE_OFF: begin
                    p.word_first  = {MT_CV2, UMP_GROUP, st, 1'b0, d1, 8'h00};
                    p.word_second = {vel_to_16(d2), 16'h0000};
                end
                OP_NOTE_ON: begin
                    if (d2 == 7'd0) begin
                        p.word_first  = {MT_CV2, UMP_GROUP, OP_NOTE_OFF, st[3:0],
                                         1'b0, d1, 8'h00};
                        p.word_second = {VEL_CENTRE, 16'h0000};
                    end else begin
                        p.word_first  = {MT_CV2, UMP_GROUP, st, 1'b0, d1, 8'h00};
                        p.word_second = {vel_to_16(d2), 16'h0000};
                    end
                end
                OP_POLY_PRESS: begin
                    p.word_first  = {MT_CV2, UMP_GROUP, st, 1'b0, d1, 8'h00};
                    p.word_second = val_to_32(d2);
                end
                OP_CTRL: begin
                    if (d1 == CC_BANK_MSB || d1 == CC_DATA_MSB || d1 == CC_BANK_LSB ||
                        d1 == CC_DATA_LSB || (d1 >= CC_NRPN_LSB && d1 <= CC_RPN_MSB)) begin
                        p.result_code = RC_UNSUPPORTED;
                    end else begin
                        p.word_first  = {MT_CV2, UMP_GROUP, st, 1'b0, d1, 8'h00};
                        p.word_second = val_to_32(d2);
                    end
                end
                OP_PROGRAM: begin
                    p.word_first  = {MT_CV2, UMP_GROUP, st, 16'h0000};
                    p.word_second = {1'b0, d1, 24'h000000};
                end
                OP_CHAN_PRESS: begin
                    p.word_first  = {MT_CV2, UMP_GROUP, st, 16'h0000};
                    p.word_second = val_to_32(d1);
                end
                OP_PITCH_BEND: begin
                    p.word_first  = {MT_CV2, UMP_GROUP, st, 16'h0000};
                    p.word_second = bend_to_32({d2, d1});
                end
                default: begin
                    p.result_code = RC_UNSUPPORTED;
                end
            endcase
        end
        if (p.result_code == RC_UNSUPPORTED) begin
            p.word_first  = '0;
            p.word_second = '0;
        end
        return p;
    endfunction

    // Random data byte: bit 7 always random, low bits often at a scaling corner
    function automatic logic [7:0] pick_data();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: v[6:0] = 7'h00;
                1: v[6:0] = 7'h40;
                2: v[6:0] = 7'h7F;
                3: v[6:0] = 7'h3F;
                default: v[6:0] = 7'h41;
            endcase
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Present one message and hold it until the core takes it. Gaps with
    // valid low go in front; the payload is scrambled while idle.
    task automatic send_msg(input logic [7:0] st, input logic [7:0] d1,
                            input logic [7:0] d2, input logic known, input t_packet want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid       <= 1'b0;
            i_status_in   <= 8'($urandom);
            i_data_first  <= 8'($urandom);
            i_data_second <= 8'($urandom);
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_status_in   <= st;
        i_data_first  <= d1;
        i_data_second <= d2;
        cur_known     <= known;
        cur_want      <= want;
        do @(posedge i_clk); while (!in_take);
    endtask

    // Receiver: stall at random, never during reset
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Sample both channels mid-cycle, where nothing is moving. A transfer seen
    // here completes at the next rising edge, so record the expectation first,
    // then retire any packet leaving the core.
    always @(negedge i_clk) begin
        in_take  = i_rst_n && i_valid && !o_stall;
        out_take = i_rst_n && o_valid && !i_stall;
        if (in_take) begin
            want_pkt = cur_known ? cur_want
                                 : translate_msg(i_status_in, i_data_first, i_data_second);
            due_packets.push_back(want_pkt);
            n_sent++;
            if (want_pkt.result_code == RC_UNSUPPORTED) n_unsupported++;
            else if (i_status_in[7:4] == OP_SYSTEM) n_system++;
            else n_voice++;
        end
        if (out_take) begin
            if (due_packets.size() == 0) begin
                report_mismatch($sformatf("unexpected packet %h %h rc %b",
                                          o_word_first, o_word_second, o_result_code));
            end else begin
                want_pkt = due_packets.pop_front();
                n_checked++;
                if (o_word_first !== want_pkt.word_first)
                    report_mismatch($sformatf("packet %0d word_first %h, want %h",
                                              n_checked, o_word_first, want_pkt.word_first));
                if (o_word_second !== want_pkt.word_second)
                    report_mismatch($sformatf("packet %0d word_second %h, want %h",
                                              n_checked, o_word_second, want_pkt.word_second));
                if (o_result_code !== want_pkt.result_code)
                    report_mismatch($sformatf("packet %0d result_code %b, want %b",
                                              n_checked, o_result_code, want_pkt.result_code));
            end
        end
    end

    initial begin
        logic [7:0] st;
        logic [7:0] d1;
        logic [7:0] d2;
        int         k;
        int         drain;

        // Hold reset from the start, then release at an edge
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First regime: sender idles a third of the time, receiver stalls half
        send_idle_pct  = 33;
        recv_stall_pct = 50;

        // Walk the directed table; typed rows carry their own packet
        for (int r = 0; r < N_DIR; r++) begin
            send_msg(dir_rows[r].st, dir_rows[r].d1, dir_rows[r].d2, dir_rows[r].known,
                     '{dir_rows[r].w0, dir_rows[r].w1, dir_rows[r].rc});
        end

        // Random traffic in three regimes: the same idling ratios, then swapped, then flat out
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 33 : (ph == 1) ? 50 : 0;
            recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                k = $urandom_range(99);
                if (k < 5) begin
                    st = 8'($urandom_range(8'h7F));
                end else if (k < 17) begin
                    st = 8'($urandom_range(8'hFF, 8'hF0));
                end else begin
                    st = {4'($urandom_range(OP_PITCH_BEND, OP_NOTE_OFF)), 4'($urandom)};
                end
                d1 = pick_data();
                d2 = pick_data();
                // Steer some controllers onto the reserved numbers
                if (st[7:4] == OP_CTRL && $urandom_range(9) < 3) begin
                    case ($urandom_range(4))
                        0: d1[6:0] = CC_BANK_MSB;
                        1: d1[6:0] = CC_DATA_MSB;
                        2: d1[6:0] = CC_BANK_LSB;
                        3: d1[6:0] = CC_DATA_LSB;
                        default: d1[6:0] = 7'($urandom_range(CC_RPN_MSB, CC_NRPN_LSB));
                    endcase
                end
                // Zero velocity, sometimes with bit 7 set so only masking makes it zero
                if (st[7:4] == OP_NOTE_ON && $urandom_range(99) < 15) begin
                    d2[6:0] = 7'd0;
                end
                send_msg(st, d1, d2, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every due packet, then wait on for strays
        drain = 0;
        while (due_packets.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (due_packets.size() != 0)
            report_mismatch($sformatf("%0d packets never arrived", due_packets.size()));

        $display("Summary: %0d messages in, %0d packets checked",
                 n_sent, n_checked);
        $display("Summary: %0d voice, %0d system, %0d unsupported; all opcodes, %s",
                 n_voice, n_system, n_unsupported,
                 "reserved controllers and scaling corners under three flow-control mixes");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
